// ===== rtl/core/piecewise_linear_interpolator_top_assert.svh =====
// Assertion macros for the piecewise linear interpolator.
// Each check is sampled on the rising edge of clk and is off while rst is high.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_TOP_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_TOP_ASSERT_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define PLI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pli assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define PLI_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pli assertion failed");
`else
`define PLI_ASSERT_IMP(label, ante, cons)
`define PLI_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/pli_pkg.sv =====
package pli_pkg;

  // Field widths
  localparam int DATA_W  = 32;
  localparam int INDEX_W = 6;
  localparam int CFG_W   = 7;

  // Serial multiply / divide widths: magnitudes of 33-bit differences
  localparam int MAG_W   = DATA_W + 1;
  localparam int PROD_W  = 2 * MAG_W;
  localparam int STEP_W  = $clog2(PROD_W);

  // Default table size
  localparam int TABLE_DEPTH_DEF = 64;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK,
    STAT_FEW_POINTS,
    STAT_NO_INTERVAL,
    STAT_ZERO_WIDTH
  } pli_status_t;

  // Top-level sequencer states
  typedef enum logic [2:0] {
    PS_IDLE,
    PS_FIRST,
    PS_LOW,
    PS_LAST,
    PS_HIGH,
    PS_SCAN,
    PS_LINE,
    PS_RESULT
  } pli_state_t;

  // Line unit states
  typedef enum logic [2:0] {
    LS_IDLE,
    LS_PREP,
    LS_MUL,
    LS_DIV,
    LS_FIN
  } pli_line_state_t;

  // One breakpoint pair
  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] f;
  } pli_entry_t;

  // Interval and query handed to the line unit
  typedef struct packed {
    logic signed [DATA_W-1:0] x0;
    logic signed [DATA_W-1:0] x1;
    logic signed [DATA_W-1:0] f0;
    logic signed [DATA_W-1:0] f1;
    logic signed [DATA_W-1:0] q;
  } pli_line_req_t;

  // Line unit answer
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    pli_status_t              status;
  } pli_line_rsp_t;

endpackage

// ===== rtl/core/pli_line.sv =====
module pli_line (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  pli_pkg::pli_line_req_t req,
  output logic                   done,
  output pli_pkg::pli_line_rsp_t rsp
);
  import pli_pkg::*;

  pli_line_state_t state, state_next;

  logic signed [MAG_W-1:0]  dx, df, dq;
  logic signed [DATA_W-1:0] f0;
  logic [MAG_W-1:0]         mcand, dvsr, rem;
  logic [PROD_W-1:0]        acc;
  logic [STEP_W-1:0]        cnt;
  logic                     neg, zero_w;

  logic capture, prep, mul_en, div_en, fin;

  logic [MAG_W-1:0]         mag_df, mag_dq, mag_dx;
  logic [MAG_W:0]           mul_sum, trial, trial_diff;
  logic                     trial_ge;
  logic [MAG_W:0]           qmag;
  logic signed [MAG_W+1:0]  f0x, qx, r;
  logic signed [DATA_W-1:0] sat_val;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      LS_IDLE: if (start) state_next = LS_PREP;
      LS_PREP: state_next = (dx == '0) ? LS_FIN : LS_MUL;
      LS_MUL:  if (cnt == '0) state_next = LS_DIV;
      LS_DIV:  if (cnt == '0) state_next = LS_FIN;
      LS_FIN:  state_next = LS_IDLE;
      default: state_next = LS_IDLE;
    endcase
  end

  // State decode
  always_comb begin
    capture = 1'b0;
    prep    = 1'b0;
    mul_en  = 1'b0;
    div_en  = 1'b0;
    fin     = 1'b0;
    unique case (state)
      LS_IDLE: capture = start;
      LS_PREP: prep    = 1'b1;
      LS_MUL:  mul_en  = 1'b1;
      LS_DIV:  div_en  = 1'b1;
      LS_FIN:  fin     = 1'b1;
      default: capture = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LS_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
    end
  end

  // Magnitudes of the differences
  assign mag_df = df[MAG_W-1] ? MAG_W'(-df) : MAG_W'(df);
  assign mag_dq = dq[MAG_W-1] ? MAG_W'(-dq) : MAG_W'(dq);
  assign mag_dx = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);

  // Shift-add multiply step: one multiplier bit a cycle
  assign mul_sum = {1'b0, acc[PROD_W-1:MAG_W]} + (acc[0] ? {1'b0, mcand} : '0);

  // Restoring divide step: one quotient bit a cycle
  assign trial      = {rem, acc[PROD_W-1]};
  assign trial_diff = trial - {1'b0, dvsr};
  assign trial_ge   = trial >= {1'b0, dvsr};

  // Quotients of 2^33 and above saturate whatever f0 is, so clamp there
  assign qmag = (|acc[PROD_W-1:MAG_W]) ? {1'b1, {MAG_W{1'b0}}} : {1'b0, acc[MAG_W-1:0]};
  assign f0x  = {{(MAG_W+2-DATA_W){f0[DATA_W-1]}}, f0};
  assign qx   = {1'b0, qmag};
  assign r    = neg ? f0x - qx : f0x + qx;

  // Saturate to 32 bits
  always_comb begin
    if (r[MAG_W+1:DATA_W-1] == '0 || r[MAG_W+1:DATA_W-1] == '1) begin
      sat_val = r[DATA_W-1:0];
    end else if (r[MAG_W+1]) begin
      sat_val = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (capture) begin
      dx <= {req.x1[DATA_W-1], req.x1} - {req.x0[DATA_W-1], req.x0};
      df <= {req.f1[DATA_W-1], req.f1} - {req.f0[DATA_W-1], req.f0};
      dq <= {req.q[DATA_W-1], req.q} - {req.x0[DATA_W-1], req.x0};
      f0 <= req.f0;
    end
    if (prep) begin
      zero_w <= (dx == '0);
      mcand  <= mag_df;
      dvsr   <= mag_dx;
      acc    <= {{MAG_W{1'b0}}, mag_dq};
      neg    <= df[MAG_W-1] ^ dq[MAG_W-1] ^ dx[MAG_W-1];
      cnt    <= STEP_W'(MAG_W - 1);
    end
    if (mul_en) begin
      acc <= {mul_sum, acc[MAG_W-1:1]};
      if (cnt == '0) begin
        cnt <= STEP_W'(PROD_W - 1);
        rem <= '0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
    if (div_en) begin
      rem <= trial_ge ? trial_diff[MAG_W-1:0] : trial[MAG_W-1:0];
      acc <= {acc[PROD_W-2:0], trial_ge};
      cnt <= cnt - 1'b1;
    end
    if (fin) begin
      if (zero_w) begin
        rsp.value  <= '0;
        rsp.status <= STAT_ZERO_WIDTH;
      end else begin
        rsp.value  <= sat_val;
        rsp.status <= STAT_OK;
      end
    end
  end

endmodule

// ===== rtl/core/piecewise_linear_interpolator_top.sv =====
// Piecewise linear interpolator: breakpoint table with serial interval search.
// Write word: stored in the table, no result. Evaluate word: a table search over the
// points in use, then a bit-serial multiply and divide when the query falls inside an
// interval or beyond either end of the table; one word at a time.
// Synchronous active-high reset clears control and sets points_in_use to 0;
// the table itself is not cleared and holds no defined value until written.
module piecewise_linear_interpolator_top #(
  parameter int TABLE_DEPTH = pli_pkg::TABLE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pli_pkg::CFG_W-1:0]          points_in_use,
  // input words
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               command,
  input  logic [pli_pkg::INDEX_W-1:0]        point_index,
  input  logic signed [pli_pkg::DATA_W-1:0]  point_x,
  input  logic signed [pli_pkg::DATA_W-1:0]  point_f,
  input  logic signed [pli_pkg::DATA_W-1:0]  query_x,
  // result words
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [pli_pkg::DATA_W-1:0]  value,
  output logic [1:0]                         status
);
  import pli_pkg::*;

  `include "piecewise_linear_interpolator_top_assert.svh"

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  pli_state_t state, state_next;

  logic [CFG_W-1:0]         pts_reg;
  logic [CNT_W-1:0]         n_cfg, n_less;
  logic                     few;
  logic [AW-1:0]            last_idx, prelast_idx, idx, rd_addr;
  logic signed [DATA_W-1:0] q;
  pli_entry_t               mem [TABLE_DEPTH];
  pli_entry_t               rd_q, ent_a, ent_b;
  logic signed [DATA_W-1:0] res_value;
  pli_status_t              res_status;

  logic in_fire, eval_go, wr_go, out_free, out_load;
  logic q_le_rd, q_ge_rd, hit, hit_eq;
  logic line_start, line_done;
  pli_line_req_t line_req;
  pli_line_rsp_t line_rsp;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pts_reg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      pts_reg <= points_in_use;
    end
  end

  // Points in use, capped at the table depth
  assign n_cfg  = (int'(pts_reg) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : CNT_W'(pts_reg);
  assign n_less = n_cfg - 1'b1;
  assign few    = n_cfg < CNT_W'(2);

  // Handshake
  assign in_fire  = in_valid && in_ready;
  assign eval_go  = in_fire && command;
  assign wr_go    = in_fire && !command && (int'(point_index) < TABLE_DEPTH);
  assign out_free = !out_valid || out_ready;
  assign out_load = (state == PS_RESULT) && out_free;

  // Comparisons against the word just read
  assign q_le_rd = q <= rd_q.x;
  assign q_ge_rd = q >= rd_q.x;
  assign hit     = (q >= ent_a.x) && q_le_rd;
  assign hit_eq  = (q == ent_a.x) || (q == rd_q.x);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      PS_IDLE:   if (eval_go) state_next = few ? PS_RESULT : PS_FIRST;
      PS_FIRST:  state_next = q_le_rd ? PS_LOW : PS_LAST;
      PS_LOW:    state_next = PS_LINE;
      PS_LAST:   state_next = q_ge_rd ? PS_HIGH : PS_SCAN;
      PS_HIGH:   state_next = PS_LINE;
      PS_SCAN: begin
        if (hit) begin
          state_next = hit_eq ? PS_RESULT : PS_LINE;
        end else if (idx == last_idx) begin
          state_next = PS_RESULT;
        end
      end
      PS_LINE:   if (line_done) state_next = PS_RESULT;
      PS_RESULT: if (out_free) state_next = PS_IDLE;
      default:   state_next = PS_IDLE;
    endcase
  end

  // Outputs of the sequencer: input ready, table address, line unit launch
  always_comb begin
    in_ready   = 1'b0;
    rd_addr    = '0;
    line_start = 1'b0;
    unique case (state)
      PS_IDLE:   in_ready = 1'b1;
      PS_FIRST:  rd_addr = q_le_rd ? AW'(1) : last_idx;
      PS_LOW:    line_start = 1'b1;
      PS_LAST:   rd_addr = q_ge_rd ? prelast_idx : AW'(1);
      PS_HIGH:   line_start = 1'b1;
      PS_SCAN: begin
        rd_addr    = idx + 1'b1;
        line_start = hit && !hit_eq;
      end
      PS_LINE:   in_ready = 1'b0;
      PS_RESULT: in_ready = 1'b0;
      default:   in_ready = 1'b0;
    endcase
  end

  // Interval for the line unit: end interval at the top, else previous and current
  always_comb begin
    line_req.q = q;
    if (state == PS_HIGH) begin
      line_req.x0 = rd_q.x;
      line_req.f0 = rd_q.f;
      line_req.x1 = ent_b.x;
      line_req.f1 = ent_b.f;
    end else begin
      line_req.x0 = ent_a.x;
      line_req.f0 = ent_a.f;
      line_req.x1 = rd_q.x;
      line_req.f1 = rd_q.f;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Breakpoint table, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_go) begin
      mem[AW'(point_index)] <= '{x: point_x, f: point_f};
    end
    rd_q <= mem[rd_addr];
  end

  // Search datapath
  always_ff @(posedge clk) begin
    unique case (state)
      PS_IDLE: begin
        if (eval_go) begin
          q           <= query_x;
          last_idx    <= n_less[AW-1:0];
          prelast_idx <= n_less[AW-1:0] - 1'b1;
          res_value   <= '0;
          res_status  <= STAT_FEW_POINTS;
        end
      end
      PS_FIRST: ent_a <= rd_q;
      PS_LAST: begin
        ent_b <= rd_q;
        idx   <= AW'(1);
      end
      PS_SCAN: begin
        if (hit) begin
          res_status <= STAT_OK;
          res_value  <= (q == ent_a.x) ? ent_a.f : rd_q.f;
        end else if (idx == last_idx) begin
          res_status <= STAT_NO_INTERVAL;
          res_value  <= '0;
        end else begin
          ent_a <= rd_q;
          idx   <= idx + 1'b1;
        end
      end
      PS_LINE: begin
        if (line_done) begin
          res_value  <= line_rsp.value;
          res_status <= line_rsp.status;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      value  <= res_value;
      status <= res_status;
    end
  end

  // Line through one interval: bit-serial multiply then divide
  pli_line u_line (
    .clk   (clk),
    .rst   (rst),
    .start (line_start),
    .req   (line_req),
    .done  (line_done),
    .rsp   (line_rsp)
  );

  // Checks
  `PLI_ASSERT_IMP(a_done_in_line, line_done, state == PS_LINE)
  `PLI_ASSERT_IMP(a_scan_in_range, state == PS_SCAN, idx <= last_idx)
  `PLI_ASSERT_NXT(a_few_points, eval_go && few, state == PS_RESULT && res_status == STAT_FEW_POINTS)
  `PLI_ASSERT_NXT(a_out_from_result, state != PS_RESULT && !out_valid, !out_valid)

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import pli_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;
  localparam int WORD_TARGET = 1950;
  localparam int PRINT_CAP   = 40;

  typedef struct {
    logic                     command;
    logic [INDEX_W-1:0]       slot;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] f;
    logic signed [DATA_W-1:0] query;
  } interp_word_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    pli_status_t              status;
  } interp_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_W-1:0]         points_in_use = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     command = CMD_WRITE;
  logic [INDEX_W-1:0]       point_index = '0;
  logic signed [DATA_W-1:0] point_x = '0;
  logic signed [DATA_W-1:0] point_f = '0;
  logic signed [DATA_W-1:0] query_x = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] value;
  logic [1:0]               status;

  // predictor copy of the table and of the point count
  logic signed [DATA_W-1:0] tbl_x [DEPTH];
  logic signed [DATA_W-1:0] tbl_f [DEPTH];
  logic [CFG_W-1:0]         tbl_points = '0;

  // stimulus-side view of the abscissae, for aiming queries
  logic signed [DATA_W-1:0] gen_x [DEPTH];

  interp_word_t   pending_words [$];
  interp_result_t expected_results [$];
  interp_word_t   cur_word;
  interp_result_t want;
  int  words_queued = 0;
  int  words_taken = 0;
  int  send_gap = 0;
  int  ready_hold = 0;
  int  error_count = 0;
  bit  no_gaps = 1'b0;

  piecewise_linear_interpolator_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .points_in_use (points_in_use),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .point_index   (point_index),
    .point_x       (point_x),
    .point_f       (point_f),
    .query_x       (query_x),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .value         (value),
    .status        (status)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic bit [63:0] magnitude(input longint a);
    return (a < 0) ? -a : a;
  endfunction

  // line through interval i, evaluated at q
  function automatic void line_through(input int i, input longint q,
                                       output logic signed [DATA_W-1:0] v,
                                       output pli_status_t st);
    longint x0, x1, f0, f1, dx, df, dq, r;
    bit [63:0] quo;
    bit neg;
    x0 = tbl_x[i];
    x1 = tbl_x[i+1];
    f0 = tbl_f[i];
    f1 = tbl_f[i+1];
    dx = x1 - x0;
    df = f1 - f0;
    dq = q - x0;
    if (dx == 0) begin
      v  = '0;
      st = STAT_ZERO_WIDTH;
    end else begin
      quo = (magnitude(df) * magnitude(dq)) / magnitude(dx);
      neg = ((df < 0) != (dq < 0)) != (dx < 0);
      // clamp the quotient well past the 32-bit range before adding f0
      if (quo > 64'd17179869184) r = neg ? -64'sd4294967296 : 64'sd4294967296;
      else r = neg ? -$signed(quo) : $signed(quo);
      r = r + f0;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      v  = r[DATA_W-1:0];
      st = STAT_OK;
    end
  endfunction

  function automatic void interp_at(input logic signed [DATA_W-1:0] qx,
                                    output logic signed [DATA_W-1:0] v,
                                    output pli_status_t st);
    int     m;
    longint q;
    bit     found;
    m     = (tbl_points > DEPTH) ? DEPTH : int'(tbl_points);
    q     = qx;
    v     = '0;
    st    = STAT_NO_INTERVAL;
    found = 1'b0;
    if (m < 2) begin
      st = STAT_FEW_POINTS;
    end else if (q <= tbl_x[0]) begin
      line_through(0, q, v, st);
    end else if (q >= tbl_x[m-1]) begin
      line_through(m - 2, q, v, st);
    end else begin
      for (int i = 0; i + 1 < m && !found; i++) begin
        if (q >= tbl_x[i] && q <= tbl_x[i+1]) begin
          found = 1'b1;
          if (q == tbl_x[i]) begin
            v  = tbl_f[i];
            st = STAT_OK;
          end else if (q == tbl_x[i+1]) begin
            v  = tbl_f[i+1];
            st = STAT_OK;
          end else begin
            line_through(i, q, v, st);
          end
        end
      end
    end
  endfunction

  function automatic void predict_word(input interp_word_t w);
    interp_result_t r;
    if (w.command == CMD_WRITE) begin
      tbl_x[w.slot] = w.x;
      tbl_f[w.slot] = w.f;
    end else begin
      interp_at(w.query, r.value, r.status);
      expected_results.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic longint rand_between(input longint lo, input longint hi);
    bit [63:0] span, pick;
    span = hi - lo + 1;
    pick = {$urandom(), $urandom()};
    return lo + $signed(pick % span);
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_write(input int slot, input logic signed [DATA_W-1:0] x,
                            input logic signed [DATA_W-1:0] f);
    interp_word_t w;
    w.command = CMD_WRITE;
    w.slot    = slot[INDEX_W-1:0];
    w.x       = x;
    w.f       = f;
    w.query   = $urandom();
    gen_x[slot] = x;
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic push_eval(input logic signed [DATA_W-1:0] q);
    interp_word_t w;
    w.command = CMD_EVAL;
    w.slot    = INDEX_W'($urandom());
    w.x       = $urandom();
    w.f       = $urandom();
    w.query   = q;
    pending_words.push_back(w);
    words_queued++;
  endtask

  // returns at a rising edge once every queued word is taken and nothing is owed
  task automatic wait_idle();
    while (words_taken < words_queued || expected_results.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_points(input logic [CFG_W-1:0] n);
    wait_idle();
    cfg_valid     <= 1'b1;
    points_in_use <= n;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    tbl_points = n;
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_word(cur_word);
        words_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          in_valid    <= 1'b1;
          command     <= cur_word.command;
          point_index <= cur_word.slot;
          point_x     <= cur_word.x;
          point_f     <= cur_word.f;
          query_x     <= cur_word.query;
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      ready_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= PRINT_CAP)
            $display("%0t: result word with none owed: value %0d status %0d",
                     $time, value, status);
        end else begin
          want = expected_results.pop_front();
          if (value !== want.value) begin
            error_count++;
            if (error_count <= PRINT_CAP)
              $display("%0t: value expected %0d actual %0d", $time, want.value, value);
          end
          if (status !== want.status) begin
            error_count++;
            if (error_count <= PRINT_CAP)
              $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          end
        end
      end
      // receiver back-pressure
      if (ready_hold > 0) begin
        ready_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) ready_hold = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int     phase_no, n, m, nevals, slot, pick;
    longint acc, stepmax, lo, hi, q, fv;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // too few points, straight after reset and with one point set: the result does not depend on the table
    push_eval(Q_MIN);
    set_points(7'd1);
    push_write(0, Q_MAX, Q_MIN);
    push_eval('0);

    // extreme abscissae and values
    set_points(7'd4);
    push_write(0, Q_MIN, Q_MAX);
    push_write(1, -Q_ONE, '0);
    push_write(2, Q_ONE, Q_MIN);
    push_write(3, Q_MAX, -32'sd1);
    push_eval(Q_MIN);
    push_eval(-Q_ONE);
    push_eval(Q_ONE);
    push_eval(Q_MAX);
    push_eval('0);
    push_eval(Q_MIN + 32'sd1);
    push_eval(Q_MAX - 32'sd1);

    // zero-width first and last intervals
    set_points(7'd3);
    push_write(0, 5 * Q_ONE, 32'sd7);
    push_write(1, 5 * Q_ONE, 32'sd9);
    push_write(2, 5 * Q_ONE, -32'sd3);
    push_eval('0);
    push_eval(10 * Q_ONE);
    push_eval(5 * Q_ONE);

    // steep unit-width interval: quotient far past 32 bits, saturates both ways
    set_points(7'd2);
    push_write(0, '0, Q_MIN);
    push_write(1, 32'sd1, Q_MAX);
    push_eval(Q_MAX);
    push_eval(Q_MIN);

    // random phases: sorted table with random content, then queries and noise
    phase_no = 0;
    while (words_queued < WORD_TARGET) begin
      pick = $urandom_range(0, 99);
      if (phase_no == 0) n = 127;
      else if (phase_no == 1) n = 64;
      else if (phase_no == 2) n = 2;
      else if (pick < 4) n = $urandom_range(0, 1);
      else if (pick < 60) n = $urandom_range(2, 8);
      else if (pick < 88) n = $urandom_range(9, 64);
      else n = $urandom_range(65, 127);
      phase_no++;
      set_points(n[CFG_W-1:0]);
      no_gaps = ($urandom_range(0, 4) == 0);
      m = (n > DEPTH) ? DEPTH : n;

      // ascending abscissae, occasionally repeated
      stepmax = 64'hFFFF_FFFF / ((m > 1) ? m - 1 : 1);
      case ($urandom_range(0, 3))
        0: if (stepmax > 16) stepmax = 16;
        1: if (stepmax > 65536) stepmax = 65536;
        2: if (stepmax > 4194304) stepmax = 4194304;
        default: ;
      endcase
      acc = rand_between(-64'sd2147483648,
                         64'sd2147483647 - ((m > 1) ? m - 1 : 0) * stepmax);
      pick = $urandom_range(0, 2);
      for (int i = 0; i < m; i++) begin
        if (pick == 0) fv = rand_between(-(64'sd1 << 20), 64'sd1 << 20);
        else if ($urandom_range(0, 15) == 0) fv = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
        else fv = $signed($urandom());
        push_write(i, acc[DATA_W-1:0], fv[DATA_W-1:0]);
        if (i + 1 < m)
          acc = acc + (($urandom_range(0, 19) == 0) ? 0 : rand_between(1, stepmax));
      end

      nevals = $urandom_range(8, 40);
      for (int k = 0; k < nevals; k++) begin
        // noise: overwrite any slot, which may unsort the table
        if ($urandom_range(0, 11) == 0)
          push_write($urandom_range(0, DEPTH - 1), $urandom(), $urandom());
        if (m < 2) begin
          q = $signed($urandom());
        end else begin
          lo = gen_x[0];
          hi = gen_x[m-1];
          if (lo > hi) begin
            acc = lo;
            lo  = hi;
            hi  = acc;
          end
          slot = $urandom_range(0, m - 1);
          case ($urandom_range(0, 9))
            0, 1, 2: q = gen_x[slot];
            3:       q = gen_x[slot] + rand_between(-2, 2);
            4, 5, 6: q = rand_between(lo, hi);
            7:       q = ($urandom_range(0, 3) == 0) ? Q_MIN : rand_between(Q_MIN, lo);
            8:       q = ($urandom_range(0, 3) == 0) ? Q_MAX : rand_between(hi, Q_MAX);
            default: q = $signed($urandom());
          endcase
          if (q > Q_MAX) q = Q_MAX;
          if (q < Q_MIN) q = Q_MIN;
        end
        push_eval(q[DATA_W-1:0]);
      end
    end

    // drain, then allow for one full evaluation's latency
    wait_idle();
    repeat (200) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("piecewise_linear_interpolator_top: match");
    end else begin
      $display("piecewise_linear_interpolator_top: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("piecewise_linear_interpolator_top: mismatch");
    $finish;
  end

endmodule
